@@ sv/group_scatter_matvec_assert.svh @@
// Assertion macros shared by the group scatter matrix-vector block.
`ifndef GROUP_SCATTER_MATVEC_ASSERT_SVH
`define GROUP_SCATTER_MATVEC_ASSERT_SVH
`ifndef SYNTHESIS
`define GSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("group_scatter_matvec: same-cycle check failed");
`define GSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("group_scatter_matvec: next-cycle check failed");
`else
`define GSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/gsm_pkg.sv @@
// Shared types, codes and constants of the group scatter matrix-vector block.
`default_nettype none
package gsm_pkg;

  localparam int MAX_GROUPS = 8;
  localparam int MAX_NODES  = 8;
  localparam int LIM_G      = (MAX_GROUPS < 8) ? MAX_GROUPS : 8;
  localparam int LIM_N      = (MAX_NODES < 8) ? MAX_NODES : 8;
  localparam int N_CELLS    = LIM_G;

  localparam int GRP_W  = 3;
  localparam int NODE_W = 3;
  localparam int CNT_W  = 4;
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * VAL_W;
  // Eight full-range products plus the rounding half fit in 67 signed bits.
  localparam int ACC_W  = PROD_W + 3;

  localparam logic [1:0] OP_LOAD_COEF = 2'd0;
  localparam logic [1:0] OP_LOAD_AVG  = 2'd1;
  localparam logic [1:0] OP_LOAD_FLUX = 2'd2;
  localparam logic [1:0] OP_COMPUTE   = 2'd3;

  localparam logic [1:0] CFG_GROUP_COUNT   = 2'd0;
  localparam logic [1:0] CFG_NODE_COUNT    = 2'd1;
  localparam logic [1:0] CFG_COHERENT_MODE = 2'd2;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // One partial sum travelling down the row of cells.
  typedef struct packed {
    logic                    valid;
    logic [GRP_W-1:0]        grp;
    logic [NODE_W-1:0]       node;
    logic                    last;
    logic signed [ACC_W-1:0] sum;
  } link_t;

  // Store write broadcast to the cells; the cell whose group matches takes it.
  typedef struct packed {
    logic              coef_we;
    logic              flux_we;
    logic [GRP_W-1:0]  src_grp;
    logic [GRP_W-1:0]  addr;
    logic [VAL_W-1:0]  data;
  } wr_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                   input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > lim) begin
      r = lim;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/gsm_cell.sv @@
// One cell of the row: holds one source group's coefficients and flux, adds its product.
`default_nettype none
module gsm_cell import gsm_pkg::*; (
  input  wire  logic             clk,
  input  wire  logic             rst_n,
  input  wire  logic [GRP_W-1:0] cell_idx,
  input  wire  logic             adv,
  input  wire  logic [CNT_W-1:0] grp_cnt,
  input  wire  logic             coherent,
  input  wire  wr_t              wr,
  input  wire  link_t            lnk_in,
  output link_t                  lnk_out
);

  // coef_col_r holds coef[to][cell]; flux_row_r holds flux[cell][node].
  logic [VAL_W-1:0] coef_col_r [MAX_GROUPS];
  logic [VAL_W-1:0] flux_row_r [MAX_NODES];

  logic                    valid_r;
  link_t                   lnk_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [VAL_W-1:0]  coef_sel;
  logic signed [VAL_W-1:0]  flux_sel;
  logic                     use_term;

  always_ff @(posedge clk) begin
    if (wr.coef_we && (wr.src_grp == cell_idx)) begin
      coef_col_r[wr.addr] <= wr.data;
    end
    if (wr.flux_we && (wr.src_grp == cell_idx)) begin
      flux_row_r[wr.addr] <= wr.data;
    end
  end

  // Coherent mode keeps only the in-group term; full mode keeps the groups in use.
  always_comb begin
    use_term = coherent ? (lnk_in.grp == cell_idx) : ({1'b0, cell_idx} < grp_cnt);
    coef_sel = use_term ? coef_col_r[lnk_in.grp]  : '0;
    flux_sel = use_term ? flux_row_r[lnk_in.node] : '0;
    prod_nxt = coef_sel * flux_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= lnk_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lnk_r  <= lnk_in;
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    lnk_out       = lnk_r;
    lnk_out.valid = valid_r;
    lnk_out.sum   = lnk_r.sum + {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  end

endmodule
`default_nettype wire

@@ sv/gsm_seq.sv @@
// Sequencer that walks destination group and node and feeds the head of the row.
`default_nettype none
module gsm_seq import gsm_pkg::*; (
  input  wire  logic             clk,
  input  wire  logic             rst_n,
  input  wire  logic             start,
  input  wire  logic             adv,
  input  wire  logic [CNT_W-1:0] grp_cnt,
  input  wire  logic [CNT_W-1:0] node_cnt,
  output link_t                  lnk
);

  seq_state_t        state_r, state_nxt;
  logic [GRP_W-1:0]  g_r, g_nxt;
  logic [NODE_W-1:0] n_r, n_nxt;
  logic              g_end;
  logic              n_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      g_r     <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      g_r     <= g_nxt;
      n_r     <= n_nxt;
    end
  end

  always_comb begin
    g_end     = ({1'b0, g_r} == (grp_cnt - CNT_W'(1)));
    n_end     = ({1'b0, n_r} == (node_cnt - CNT_W'(1)));
    state_nxt = state_r;
    g_nxt     = g_r;
    n_nxt     = n_r;
    lnk.valid = 1'b0;
    lnk.grp   = g_r;
    lnk.node  = n_r;
    lnk.last  = g_end && n_end;
    lnk.sum   = ROUND_HALF;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_RUN;
          g_nxt     = '0;
          n_nxt     = '0;
        end
      end
      SEQ_RUN: begin
        lnk.valid = 1'b1;
        if (adv) begin
          if (n_end) begin
            n_nxt = '0;
            if (g_end) begin
              state_nxt = SEQ_IDLE;
            end else begin
              g_nxt = g_r + GRP_W'(1);
            end
          end else begin
            n_nxt = n_r + NODE_W'(1);
          end
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/group_scatter_matvec.sv @@
// Top level of the multigroup scattering matrix-vector block.
// A load beat (coefficient, averaged coefficient or flux) writes the store inside
// the cell of its source group. A compute beat starts a sequencer that sends one
// destination group and node pair per cycle, while the output is not stalled, into a
// row of eight cells, one per source group; each cell adds its registered 32x32
// product to the partial sum and passes it on, so results come out one per cycle
// while not stalled, through the row's cells and one output register. A compute run
// occupies the input until the row has drained, longer while the output side stalls;
// the row and the sequencer hold whenever the output register is full and not taken.
// The next input beat is accepted once the row has drained.
`default_nettype none
`include "group_scatter_matvec_assert.svh"
module group_scatter_matvec import gsm_pkg::*; (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  logic              cfg_we,
  input  wire  logic [1:0]        cfg_index,
  input  wire  logic [CNT_W-1:0]  cfg_data,
  input  wire  logic              in_valid,
  output logic                    in_ready,
  input  wire  logic [1:0]        in_opcode,
  input  wire  logic [GRP_W-1:0]  in_to_group,
  input  wire  logic [GRP_W-1:0]  in_from_group,
  input  wire  logic [NODE_W-1:0] in_node_index,
  input  wire  logic signed [VAL_W-1:0] in_value_a,
  input  wire  logic signed [VAL_W-1:0] in_value_b,
  output logic                    out_valid,
  input  wire  logic              out_ready,
  output logic [GRP_W-1:0]        out_group,
  output logic [NODE_W-1:0]       out_node,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last
);

  logic [CNT_W-1:0] group_count_r;
  logic [CNT_W-1:0] node_count_r;
  logic             coherent_r;
  logic [CNT_W-1:0] grp_cnt;
  logic [CNT_W-1:0] node_cnt;

  logic             in_accept;
  logic             adv;
  logic             chain_busy;
  logic [VAL_W:0]   avg_sum;
  wr_t              wr;
  link_t            chain_lnk [N_CELLS+1];
  link_t            tail;

  logic                   out_valid_r;
  logic [GRP_W-1:0]       out_group_r;
  logic [NODE_W-1:0]      out_node_r;
  logic [VAL_W-1:0]       out_value_r;
  logic                   out_last_r;
  logic [VAL_W-1:0]       sat_value;
  logic [ACC_W-VAL_W-FRAC_W:0] sum_top;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_count_r <= CNT_W'(1);
      node_count_r  <= CNT_W'(1);
      coherent_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GROUP_COUNT:   group_count_r <= cfg_data;
        CFG_NODE_COUNT:    node_count_r  <= cfg_data;
        CFG_COHERENT_MODE: coherent_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign grp_cnt  = clamp_count(group_count_r, CNT_W'(LIM_G));
  assign node_cnt = clamp_count(node_count_r, CNT_W'(LIM_N));

  // The row and the sequencer move only when the output register can take a beat.
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !chain_lnk[0].valid && !chain_busy;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    chain_busy = 1'b0;
    for (int i = 1; i <= N_CELLS; i++) begin
      chain_busy = chain_busy | chain_lnk[i].valid;
    end
  end

  // The mean of two coefficients rounds toward minus infinity.
  assign avg_sum = {in_value_a[VAL_W-1], in_value_a} + {in_value_b[VAL_W-1], in_value_b};

  always_comb begin
    wr.coef_we = 1'b0;
    wr.flux_we = 1'b0;
    wr.src_grp = in_from_group;
    wr.addr    = in_to_group;
    wr.data    = in_value_a;
    case (in_opcode) inside
      OP_LOAD_COEF, OP_LOAD_AVG: begin
        wr.coef_we = in_accept;
        if (in_opcode == OP_LOAD_AVG) begin
          wr.data = avg_sum[VAL_W:1];
        end
      end
      OP_LOAD_FLUX: begin
        wr.flux_we = in_accept;
        wr.addr    = in_node_index;
      end
      default: ;
    endcase
  end

  gsm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept && (in_opcode == OP_COMPUTE)),
    .adv      (adv),
    .grp_cnt  (grp_cnt),
    .node_cnt (node_cnt),
    .lnk      (chain_lnk[0])
  );

  for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
    gsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (GRP_W'(c)),
      .adv      (adv),
      .grp_cnt  (grp_cnt),
      .coherent (coherent_r),
      .wr       (wr),
      .lnk_in   (chain_lnk[c]),
      .lnk_out  (chain_lnk[c+1])
    );
  end

  assign tail = chain_lnk[N_CELLS];

  // The rounding half entered at the head, so a shift finishes the rounding; out-of-range sums saturate.
  always_comb begin
    sum_top = tail.sum[ACC_W-1:VAL_W+FRAC_W-1];
    if ((&sum_top) || !(|sum_top)) begin
      sat_value = tail.sum[VAL_W+FRAC_W-1:FRAC_W];
    end else if (tail.sum[ACC_W-1]) begin
      sat_value = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail.valid) begin
      out_group_r <= tail.grp;
      out_node_r  <= tail.node;
      out_value_r <= sat_value;
      out_last_r  <= tail.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_group = out_group_r;
  assign out_node  = out_node_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  `GSM_ASSERT_NEXT(a_compute_starts, clk, rst_n, in_accept && (in_opcode == OP_COMPUTE), chain_lnk[0].valid)
  `GSM_ASSERT_NEXT(a_stall_holds_tail, clk, rst_n, !adv, $stable(tail.valid))
  `GSM_ASSERT_IMPL(a_last_after_seq, clk, rst_n, out_valid && out_last, !chain_busy)

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the multigroup scattering matrix-vector block.
`default_nettype none
module tb_top import gsm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 14;

  typedef struct {
    logic [GRP_W-1:0]  grp;
    logic [NODE_W-1:0] node;
    logic [VAL_W-1:0]  value;
    logic              last;
  } flux_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [GRP_W-1:0] in_to_group = '0;
  logic [GRP_W-1:0] in_from_group = '0;
  logic [NODE_W-1:0] in_node_index = '0;
  logic signed [VAL_W-1:0] in_value_a = '0;
  logic signed [VAL_W-1:0] in_value_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [GRP_W-1:0] out_group;
  logic [NODE_W-1:0] out_node;
  logic signed [VAL_W-1:0] out_value;
  logic out_last;

  // Shadow of the block's registers and stores.
  logic [CNT_W-1:0] group_count_sh = CNT_W'(1);
  logic [CNT_W-1:0] node_count_sh = CNT_W'(1);
  logic coherent_sh = 1'b0;
  logic [VAL_W-1:0] coef_mem [MAX_GROUPS*MAX_GROUPS];
  logic [VAL_W-1:0] flux_mem [MAX_GROUPS*MAX_NODES];
  bit coef_written [MAX_GROUPS*MAX_GROUPS];
  bit flux_written [MAX_GROUPS*MAX_NODES];

  flux_result_t scattered_flux_due[$];

  int error_count = 0;
  int beats_sent = 0;
  int compute_runs = 0;
  int results_seen = 0;
  int settings_used = 0;
  int cycle_count = 0;
  bit steady = 1'b0;
  logic hold_active = 1'b0;
  event hold_start_ev;

  group_scatter_matvec uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_to_group(in_to_group),
    .in_from_group(in_from_group),
    .in_node_index(in_node_index),
    .in_value_a(in_value_a),
    .in_value_b(in_value_b),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_group(out_group),
    .out_node(out_node),
    .out_value(out_value),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               scattered_flux_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int eff_count(input logic [CNT_W-1:0] c, input int lim);
    int r;
    r = int'(c);
    if (r < 1) r = 1;
    if (r > lim) r = lim;
    return r;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_idle_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return ($urandom_range(0, 1) != 0) ? 32'h0000_8000 : 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: return VAL_W'(int'($urandom_range(0, 2**20 - 1)) - 2**19);
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("Mismatch on %s at cycle %0d: got %0h, expected %0h", what, cycle_count,
             got, want);
    error_count++;
  endtask

  // Expected results of one compute beat, in group-major, node-minor order.
  task automatic compute_scattered_flux();
    int ng, nn;
    longint cv, fv, p;
    logic signed [69:0] acc;
    logic signed [69:0] rnd;
    flux_result_t r;
    ng = eff_count(group_count_sh, LIM_G);
    nn = eff_count(node_count_sh, LIM_N);
    for (int g = 0; g < ng; g++) begin
      for (int n = 0; n < nn; n++) begin
        acc = '0;
        for (int f = 0; f < ng; f++) begin
          if (!coherent_sh || f == g) begin
            cv = $signed(coef_mem[g*MAX_GROUPS + f]);
            fv = $signed(flux_mem[f*MAX_NODES + n]);
            p = cv * fv;
            acc = acc + p;
          end
        end
        // Round half up to Q16.16, then saturate.
        rnd = (acc + 70'sd32768) >>> FRAC_W;
        if (rnd > 70'sd2147483647) begin
          r.value = 32'h7FFF_FFFF;
        end else if (rnd < -70'sd2147483648) begin
          r.value = 32'h8000_0000;
        end else begin
          r.value = rnd[VAL_W-1:0];
        end
        r.grp = GRP_W'(g);
        r.node = NODE_W'(n);
        r.last = (g == ng - 1) && (n == nn - 1);
        scattered_flux_due.push_back(r);
      end
    end
  endtask

  task automatic absorb_beat(input logic [1:0] op, input logic [GRP_W-1:0] tg,
                             input logic [GRP_W-1:0] fg, input logic [NODE_W-1:0] nd,
                             input logic signed [VAL_W-1:0] a,
                             input logic signed [VAL_W-1:0] b);
    longint s;
    case (op)
      OP_LOAD_COEF: begin
        coef_mem[tg*MAX_GROUPS + fg] = a;
        coef_written[tg*MAX_GROUPS + fg] = 1'b1;
      end
      OP_LOAD_AVG: begin
        // Mean of two values, rounded toward minus infinity.
        s = a;
        s = s + b;
        s = s >>> 1;
        coef_mem[tg*MAX_GROUPS + fg] = s[VAL_W-1:0];
        coef_written[tg*MAX_GROUPS + fg] = 1'b1;
      end
      OP_LOAD_FLUX: begin
        flux_mem[fg*MAX_NODES + nd] = a;
        flux_written[fg*MAX_NODES + nd] = 1'b1;
      end
      default: begin
        compute_runs++;
        compute_scattered_flux();
      end
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic [GRP_W-1:0] tg,
                           input logic [GRP_W-1:0] fg, input logic [NODE_W-1:0] nd,
                           input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 40) gap = pick_idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_to_group <= tg;
    in_from_group <= fg;
    in_node_index <= nd;
    in_value_a <= a;
    in_value_b <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    absorb_beat(op, tg, fg, nd, a, b);
  endtask

  // Loads every entry the next compute reads that has never been written.
  task automatic fill_unwritten();
    int ng, nn;
    ng = eff_count(group_count_sh, LIM_G);
    nn = eff_count(node_count_sh, LIM_N);
    for (int g = 0; g < ng; g++) begin
      for (int f = 0; f < ng; f++) begin
        if ((!coherent_sh || f == g) && !coef_written[g*MAX_GROUPS + f]) begin
          send_item(($urandom_range(0, 1) != 0) ? OP_LOAD_AVG : OP_LOAD_COEF,
                    GRP_W'(g), GRP_W'(f), NODE_W'($urandom), rand_value(), rand_value());
        end
      end
      for (int n = 0; n < nn; n++) begin
        if (!flux_written[g*MAX_NODES + n]) begin
          send_item(OP_LOAD_FLUX, GRP_W'($urandom), GRP_W'(g), NODE_W'(n),
                    rand_value(), rand_value());
        end
      end
    end
  endtask

  task automatic send_compute();
    fill_unwritten();
    send_item(OP_COMPUTE, GRP_W'($urandom), GRP_W'($urandom), NODE_W'($urandom),
              $urandom, $urandom);
  endtask

  // Sender pause: nothing new goes in until every due result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (scattered_flux_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One write, then the write enable drops so that back-to-back writes never collide.
  task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GROUP_COUNT: group_count_sh = val;
      CFG_NODE_COUNT: node_count_sh = val;
      CFG_COHERENT_MODE: coherent_sh = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CNT_W-1:0] groups, input logic [CNT_W-1:0] nodes,
                            input logic [CNT_W-1:0] mode);
    drain_results();
    write_reg(CFG_GROUP_COUNT, groups);
    write_reg(CFG_NODE_COUNT, nodes);
    write_reg(CFG_COHERENT_MODE, mode);
    settings_used++;
  endtask

  // Rounding, averaging and saturation corners with the reset counts of one by one.
  task automatic test_arith_extremes();
    send_item(OP_LOAD_COEF, 3'd7, 3'd0, 3'd7, 32'h0001_0000, 32'hFFFF_FFFF);
    send_item(OP_LOAD_FLUX, 3'd5, 3'd0, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_compute();
    send_item(OP_LOAD_AVG, 3'd0, 3'd0, 3'd3, 32'h8000_0000, 32'h8000_0000);
    send_compute();
    send_item(OP_LOAD_AVG, 3'd0, 3'd0, 3'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_compute();
    // Mean of minus one and zero floors to minus one; the product is minus half an LSB.
    send_item(OP_LOAD_AVG, 3'd0, 3'd0, 3'd0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_LOAD_FLUX, 3'd0, 3'd0, 3'd0, 32'h0000_8000, 32'h0);
    send_compute();
    send_item(OP_LOAD_AVG, 3'd0, 3'd0, 3'd0, 32'h0000_0003, 32'h0000_0000);
    send_compute();
    send_item(OP_LOAD_AVG, 3'd0, 3'd0, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_LOAD_FLUX, 3'd0, 3'd7, 3'd7, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_compute();
  endtask

  // Zero counts act as one, the spare index does nothing, mode takes only bit zero.
  task automatic test_register_decode();
    drain_results();
    write_reg(CFG_GROUP_COUNT, 4'd0);
    write_reg(CFG_NODE_COUNT, 4'd0);
    write_reg(CFG_COHERENT_MODE, 4'b1110);
    write_reg(CFG_SPARE_INDEX, 4'hF);
    settings_used++;
    send_compute();
    drain_results();
    write_reg(CFG_GROUP_COUNT, 4'd2);
    write_reg(CFG_NODE_COUNT, 4'd2);
    write_reg(CFG_COHERENT_MODE, 4'b0011);
    write_reg(CFG_SPARE_INDEX, 4'h0);
    settings_used++;
    send_compute();
  endtask

  task automatic test_random_phases();
    logic [CNT_W-1:0] groups_tbl [PHASES] = '{4'd1, 4'd2, 4'd3, 4'd0, 4'd5, 4'd2, 4'd9,
                                              4'd15};
    logic [CNT_W-1:0] nodes_tbl [PHASES] = '{4'd1, 4'd3, 4'd2, 4'd4, 4'd1, 4'd8, 4'd3,
                                             4'd15};
    logic [CNT_W-1:0] mode_tbl [PHASES] = '{4'd0, 4'd0, 4'd1, 4'd8, 4'd5, 4'd0, 4'd1,
                                            4'd0};
    int ng, nn, sel;
    logic [1:0] op;
    logic [GRP_W-1:0] tg, fg;
    logic [NODE_W-1:0] nd;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(groups_tbl[ph], nodes_tbl[ph], mode_tbl[ph]);
      steady = (ph == 2) || (ph == 5);
      ng = eff_count(group_count_sh, LIM_G);
      nn = eff_count(node_count_sh, LIM_N);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
          send_compute();
        end else begin
          // Most loads land inside the active block so that computes see them.
          if ($urandom_range(0, 3) != 0) begin
            tg = GRP_W'($urandom_range(0, ng - 1));
            fg = GRP_W'($urandom_range(0, ng - 1));
            nd = NODE_W'($urandom_range(0, nn - 1));
          end else begin
            tg = GRP_W'($urandom);
            fg = GRP_W'($urandom);
            nd = NODE_W'($urandom);
          end
          if (sel < 50) op = OP_LOAD_COEF;
          else if (sel < 70) op = OP_LOAD_AVG;
          else op = OP_LOAD_FLUX;
          send_item(op, tg, fg, nd, rand_value(), rand_value());
        end
      end
    end
    steady = 1'b0;
  endtask

  // The receiver holds off while full-size runs and loads keep coming.
  task automatic test_output_hold();
    set_config(4'd8, 4'd8, 4'd0);
    fill_unwritten();
    -> hold_start_ev;
    send_compute();
    for (int i = 0; i < 6; i++) begin
      send_item(OP_LOAD_FLUX, GRP_W'($urandom), GRP_W'($urandom), NODE_W'($urandom),
                rand_value(), rand_value());
    end
    send_compute();
    set_config(4'd8, 4'd8, 4'd1);
    send_compute();
    drain_results();
  endtask

  initial begin : hold_off
    forever begin
      @(hold_start_ev);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_active || stall_left > 0) begin
        out_ready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) stall_left = pick_idle_len();
      end
    end
  end

  always @(posedge clk) begin : check_results
    flux_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (scattered_flux_due.size() == 0) begin
        report_mismatch("unexpected result beat", out_value, 0);
      end else begin
        want = scattered_flux_due.pop_front();
        if (out_group !== want.grp) report_mismatch("out_group", out_group, want.grp);
        if (out_node !== want.node) report_mismatch("out_node", out_node, want.node);
        if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
        if (out_last !== want.last) report_mismatch("out_last", out_last, want.last);
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_arith_extremes();
    test_register_decode();
    test_random_phases();
    test_output_hold();
    drain_results();
    if (scattered_flux_due.size() != 0) begin
      report_mismatch("results never delivered", scattered_flux_due.size(), 0);
    end
    $display("Covered %0d input beats with %0d compute runs and %0d checked results,",
             beats_sent, compute_runs, results_seen);
    $display("over %0d register settings including zero, maximum and over-range counts.",
             settings_used);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
